// ===== rtl/hrmd_pkg.sv =====
// Shared types and constants for the HID report message deframer.
// No dependencies; used by the top level and the testbench.
package hrmd_pkg;

    localparam int unsigned REPORT_PAYLOAD_DEF = 63;
    localparam logic [7:0]  MAGIC_CHAR         = 8'h23;
    localparam logic [31:0] MAX_LENGTH_RST     = 32'd65536;
    localparam logic [2:0]  HDR_TYPE_BYTES     = 3'd2;
    localparam logic [2:0]  HDR_LAST_IDX       = 3'd5;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_BAD_MAG = 2'd2,
        KIND_TOO_BIG = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_MAGIC2  = 4'b0010,
        PH_HEADER  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] msg_type;
        logic [31:0] msg_length;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

endpackage

// ===== rtl/hrmd_if.sv =====
// Channel interfaces of the HID report message deframer: report bytes in,
// results out, and the max_length write port. Depends on nothing.
interface hrmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       report_start;
    modport source (output valid, data_byte, report_start, input ready);
    modport sink   (input valid, data_byte, report_start, output ready);
endinterface

interface hrmd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] msg_type;
    logic [31:0] msg_length;
    logic [7:0]  payload_byte;
    logic        last;
    modport source (output valid, kind, msg_type, msg_length, payload_byte, last,
                    input ready);
    modport sink   (input valid, kind, msg_type, msg_length, payload_byte, last,
                    output ready);
endinterface

interface hrmd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/hid_report_message_deframer.sv =====
// Top level of the HID report message deframer.
// Depends on hrmd_pkg and the channel interfaces in hrmd_if.sv.
//
//  channel | dir | beat carries                                  | modport
//  --------+-----+-----------------------------------------------+--------
//  i_in    | in  | data_byte, report_start                       | sink
//  o_out   | out | kind, msg_type, msg_length, payload_byte, last| source
//  i_cfg   | in  | data = max_length                             | sink
//
// One input beat per cycle while i_in.ready is high. A beat is parsed in the
// cycle it is accepted; its result (if any) goes to the output register, or
// to the skid register while the output register is held by a stalled o_out.
// Both are one-entry; i_in.ready drops only while the skid register is full,
// so a stalled o_out lets one more result in before input backpressure.
// i_cfg is always ready; max_length takes effect for the next header.
// Synchronous active-low reset: hunt phase, all counters zero,
// max_length = 65536, both result registers empty.
module hid_report_message_deframer #(
    parameter int unsigned REPORT_PAYLOAD = hrmd_pkg::REPORT_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrmd_in_if.sink           i_in,
    hrmd_out_if.source        o_out,
    hrmd_cfg_if.sink          i_cfg
);

    // report_left holds 0..REPORT_PAYLOAD
    localparam int unsigned RL_W = $clog2(REPORT_PAYLOAD + 1);

    // control state
    hrmd_pkg::t_phase  r_phase, n_phase;
    logic [RL_W-1:0]   r_report_left, n_report_left;
    logic [2:0]        r_hdr_idx, n_hdr_idx;
    logic [15:0]       r_type, n_type;
    logic [31:0]       r_length, n_length;
    logic [31:0]       r_payload_left, n_payload_left;
    logic [31:0]       r_max_length;

    // result registers
    logic              r_out_valid;
    logic              r_skid_valid;
    hrmd_pkg::t_result r_out, r_skid;

    logic              in_accept;
    logic              out_free;
    logic              res_valid;
    hrmd_pkg::t_result res;
    logic [31:0]       pl_dec;

    assign i_in.ready  = !r_skid_valid;
    assign in_accept   = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    assign pl_dec = (r_payload_left != 32'd0) ? r_payload_left - 32'd1 : r_payload_left;

    // parse one beat
    always_comb begin
        n_phase        = r_phase;
        n_report_left  = r_report_left;
        n_hdr_idx      = r_hdr_idx;
        n_type         = r_type;
        n_length       = r_length;
        n_payload_left = r_payload_left;
        res_valid      = 1'b0;
        res            = '0;
        if (in_accept) begin
            if (i_in.report_start) begin
                // count byte; saturate to the report payload size
                if (i_in.data_byte > 8'(REPORT_PAYLOAD)) begin
                    n_report_left = RL_W'(REPORT_PAYLOAD);
                end else begin
                    n_report_left = i_in.data_byte[RL_W-1:0];
                end
            end else if (r_report_left != '0) begin
                n_report_left = r_report_left - RL_W'(1);
                case (r_phase)
                    hrmd_pkg::PH_HUNT: begin
                        if (i_in.data_byte == hrmd_pkg::MAGIC_CHAR) begin
                            n_phase = hrmd_pkg::PH_MAGIC2;
                        end
                    end
                    hrmd_pkg::PH_MAGIC2: begin
                        if (i_in.data_byte == hrmd_pkg::MAGIC_CHAR) begin
                            n_phase   = hrmd_pkg::PH_HEADER;
                            n_hdr_idx = 3'd0;
                            n_type    = 16'd0;
                            n_length  = 32'd0;
                        end else begin
                            n_phase   = hrmd_pkg::PH_HUNT;
                            res_valid = 1'b1;
                            res.kind  = hrmd_pkg::KIND_BAD_MAG;
                        end
                    end
                    hrmd_pkg::PH_HEADER: begin
                        // big-endian: type bytes first, then length bytes
                        if (r_hdr_idx < hrmd_pkg::HDR_TYPE_BYTES) begin
                            n_type = {r_type[7:0], i_in.data_byte};
                        end else begin
                            n_length = {r_length[23:0], i_in.data_byte};
                        end
                        n_hdr_idx = r_hdr_idx + 3'd1;
                        if (r_hdr_idx == hrmd_pkg::HDR_LAST_IDX) begin
                            n_hdr_idx      = 3'd0;
                            res_valid      = 1'b1;
                            res.msg_type   = n_type;
                            res.msg_length = n_length;
                            if (n_length > r_max_length) begin
                                n_phase  = hrmd_pkg::PH_HUNT;
                                res.kind = hrmd_pkg::KIND_TOO_BIG;
                            end else begin
                                n_payload_left = n_length;
                                res.kind       = hrmd_pkg::KIND_HEADER;
                                res.last       = (n_length == 32'd0);
                                n_phase        = (n_length == 32'd0) ? hrmd_pkg::PH_HUNT
                                                                     : hrmd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    hrmd_pkg::PH_PAYLOAD: begin
                        n_payload_left   = pl_dec;
                        res_valid        = 1'b1;
                        res.kind         = hrmd_pkg::KIND_PAYLOAD;
                        res.msg_type     = r_type;
                        res.msg_length   = r_length;
                        res.payload_byte = i_in.data_byte;
                        res.last         = (pl_dec == 32'd0);
                        if (pl_dec == 32'd0) begin
                            n_phase = hrmd_pkg::PH_HUNT;
                        end
                    end
                    default: begin
                        n_phase = hrmd_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= hrmd_pkg::PH_HUNT;
            r_report_left  <= '0;
            r_hdr_idx      <= 3'd0;
            r_type         <= 16'd0;
            r_length       <= 32'd0;
            r_payload_left <= 32'd0;
            r_max_length   <= hrmd_pkg::MAX_LENGTH_RST;
        end else begin
            r_phase        <= n_phase;
            r_report_left  <= n_report_left;
            r_hdr_idx      <= n_hdr_idx;
            r_type         <= n_type;
            r_length       <= n_length;
            r_payload_left <= n_payload_left;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_length <= i_cfg.data;
            end
        end
    end

    // output register + skid: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_out_valid && o_out.ready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register + skid: payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            if (out_free) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (r_out_valid && o_out.ready && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.msg_type     = r_out.msg_type;
    assign o_out.msg_length   = r_out.msg_length;
    assign o_out.payload_byte = r_out.payload_byte;
    assign o_out.last         = r_out.last;

`ifndef SYNTHESIS
    // skid only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // payload phase always has bytes left to deliver
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hrmd_pkg::PH_PAYLOAD) |-> (r_payload_left != 32'd0))
        else $error("payload phase with zero bytes left");

    // header counter stays in range and is idle outside the header phase
    a_hdr_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_idx <= hrmd_pkg::HDR_LAST_IDX)
        && ((r_phase == hrmd_pkg::PH_HEADER) || (r_hdr_idx == 3'd0)))
        else $error("header index out of range");

    // a newly filled skid means the last cycle had a result and a stalled output
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(res_valid && r_out_valid && !o_out.ready))
        else $error("skid filled without a stalled result");
`endif

endmodule

// ===== dv/tb_hid_report_message_deframer.sv =====
// Self-checking testbench for hid_report_message_deframer: report bytes in, parsed
// message results out, max_length written between phases.
// Depends on hrmd_pkg and the channel interfaces in rtl/hrmd_if.sv.
module tb_hid_report_message_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF_NS      = 5;
    localparam int unsigned RESET_CYCLES     = 6;
    // Settling wait after a drain; only the output and skid registers hold results.
    localparam int unsigned SETTLE_CYCLES    = 16;
    localparam int unsigned IDLE_PCT         = 36;
    localparam int unsigned PHASE_ITEMS      = 70;
    localparam int unsigned NUM_PHASES       = 7;
    localparam int unsigned HOLD_OFF_CYCLES  = 400;
    // Accepted payloads are kept short so a message never swallows the run.
    localparam logic [31:0] MAX_SENT_PAYLOAD = 32'd48;
    localparam int unsigned TIMEOUT_NS       = 2_000_000;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the deframer state from the accepted input beats
    // and holds the results those beats should produce, oldest first.
    // ------------------------------------------------------------------
    class deframe_scoreboard;
        hrmd_pkg::t_result pending_results[$];
        int unsigned       n_errors;
        logic [31:0]       max_length;
        logic [5:0]        report_left;
        hrmd_pkg::t_phase  parse_phase;
        logic [2:0]        header_index;
        logic [15:0]       type_shift;
        logic [31:0]       length_shift;
        logic [31:0]       payload_left;

        function new();
            n_errors     = 0;
            max_length   = hrmd_pkg::MAX_LENGTH_RST;
            report_left  = '0;
            parse_phase  = hrmd_pkg::PH_HUNT;
            header_index = '0;
            type_shift   = '0;
            length_shift = '0;
            payload_left = '0;
        endfunction

        function void push_result(hrmd_pkg::t_kind kind, logic [15:0] mtype,
                                  logic [31:0] mlen, logic [7:0] pbyte, logic last);
            hrmd_pkg::t_result r;
            r.kind         = kind;
            r.msg_type     = mtype;
            r.msg_length   = mlen;
            r.payload_byte = pbyte;
            r.last         = last;
            pending_results.push_back(r);
        endfunction

        // One accepted input beat: count byte or report byte.
        function void note_report_byte(logic [7:0] b, logic start);
            if (start) begin
                // A new report always reloads the count, dropping unread bytes.
                report_left = (b > hrmd_pkg::REPORT_PAYLOAD_DEF)
                              ? 6'(hrmd_pkg::REPORT_PAYLOAD_DEF) : b[5:0];
                return;
            end
            if (report_left == 0)
                return;     // past the count: ignored
            report_left--;

            case (parse_phase)
                hrmd_pkg::PH_HUNT: begin
                    if (b == hrmd_pkg::MAGIC_CHAR)
                        parse_phase = hrmd_pkg::PH_MAGIC2;
                end
                hrmd_pkg::PH_MAGIC2: begin
                    if (b == hrmd_pkg::MAGIC_CHAR) begin
                        parse_phase  = hrmd_pkg::PH_HEADER;
                        header_index = '0;
                        type_shift   = '0;
                        length_shift = '0;
                    end else begin
                        parse_phase = hrmd_pkg::PH_HUNT;
                        push_result(hrmd_pkg::KIND_BAD_MAG, '0, '0, '0, 1'b0);
                    end
                end
                hrmd_pkg::PH_HEADER: begin
                    if (header_index < hrmd_pkg::HDR_TYPE_BYTES)
                        type_shift = {type_shift[7:0], b};
                    else
                        length_shift = {length_shift[23:0], b};
                    if (header_index != hrmd_pkg::HDR_LAST_IDX) begin
                        header_index++;
                    end else begin
                        header_index = '0;
                        if (length_shift > max_length) begin
                            parse_phase = hrmd_pkg::PH_HUNT;
                            push_result(hrmd_pkg::KIND_TOO_BIG, type_shift, length_shift,
                                        '0, 1'b0);
                        end else begin
                            payload_left = length_shift;
                            parse_phase  = (payload_left == 0) ? hrmd_pkg::PH_HUNT
                                                               : hrmd_pkg::PH_PAYLOAD;
                            push_result(hrmd_pkg::KIND_HEADER, type_shift, length_shift,
                                        '0, payload_left == 0);
                        end
                    end
                end
                default: begin
                    if (payload_left != 0)
                        payload_left--;
                    if (payload_left == 0)
                        parse_phase = hrmd_pkg::PH_HUNT;
                    push_result(hrmd_pkg::KIND_PAYLOAD, type_shift, length_shift, b,
                                payload_left == 0);
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            n_errors++;
        endtask

        task check_result(hrmd_pkg::t_result got);
            hrmd_pkg::t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected (kind %0d)",
                                          got.kind));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.msg_type !== want.msg_type)
                report_mismatch($sformatf("msg_type %h, want %h", got.msg_type,
                                          want.msg_type));
            if (got.msg_length !== want.msg_length)
                report_mismatch($sformatf("msg_length %h, want %h", got.msg_length,
                                          want.msg_length));
            if (got.payload_byte !== want.payload_byte)
                report_mismatch($sformatf("payload_byte %h, want %h", got.payload_byte,
                                          want.payload_byte));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #(CLK_HALF_NS) i_clk = 1'b1;
        #(CLK_HALF_NS) i_clk = 1'b0;
    end

    hrmd_in_if  in_if();
    hrmd_out_if out_if();
    hrmd_cfg_if cfg_if();

    hid_report_message_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    deframe_scoreboard sb;

    // Per-side idle odds in percent; a phase may zero them for a busy stretch.
    int unsigned in_idle_pct  = IDLE_PCT;
    int unsigned out_idle_pct = IDLE_PCT;
    // Receiver hold-off, counted down by the ready process.
    int unsigned hold_cycles  = 0;
    int unsigned phase_items;
    // Byte stream of the messages still to be cut into reports.
    logic [7:0]  stream_q[$];

    // ------------------------------------------------------------------
    // Monitors: everything is sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid === 1'b1 && in_if.ready === 1'b1)
            sb.note_report_byte(in_if.data_byte, in_if.report_start);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
            sb.max_length = cfg_if.data;
    end

    always @(posedge i_clk) begin : mon_results
        hrmd_pkg::t_result got;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.kind         = hrmd_pkg::t_kind'(out_if.kind);
            got.msg_type     = out_if.msg_type;
            got.msg_length   = out_if.msg_length;
            got.payload_byte = out_if.payload_byte;
            got.last         = out_if.last;
            sb.check_result(got);
        end
    end

    // Result receiver: random stalls, or a long hold-off when one is armed.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers: inputs change at the falling edge.
    // ------------------------------------------------------------------

    // One input beat; returns right after the edge that accepted it, with
    // valid still high so back-to-back beats need no bubble.
    task automatic send_beat(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < in_idle_pct) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= b;
        in_if.report_start <= start;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1)
            @(posedge i_clk);
    endtask

    // Stop sending, let every expected result out, then give anything that
    // produced no result time to settle.
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        wait_drained();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Any byte but the magic, so filler never starts a frame by accident.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == hrmd_pkg::MAGIC_CHAR)
            b = ~b;
        return b;
    endfunction

    // Append one message to the stream. Most are well formed with random
    // type, length and payload; the rest are bad second magics or filler.
    task automatic add_message();
        int unsigned roll;
        int unsigned sel;
        int unsigned n_noise;
        logic [15:0] mtype;
        logic [31:0] len;
        logic [31:0] cap;
        cap     = sb.max_length;
        roll    = $urandom_range(99);
        n_noise = (roll < 5) ? $urandom_range(1, 6) : $urandom_range(0, 2);
        repeat (n_noise) stream_q.push_back(noise_byte());
        if (roll < 5)
            return;
        if (roll < 17) begin
            stream_q.push_back(hrmd_pkg::MAGIC_CHAR);
            stream_q.push_back(noise_byte());
            return;
        end

        mtype = 16'($urandom);
        sel   = $urandom_range(9);
        case (sel)
            0:       len = '0;
            1:       len = cap;                                   // right at the limit
            2:       len = (cap == '1) ? 32'($urandom_range(0, 8)) : cap + 1;
            3:       len = $urandom | 32'h8000_0000;
            default: len = 32'($urandom_range(1, 12));
        endcase
        // A length the block accepts must stay short enough to actually send.
        if (len <= cap && len > MAX_SENT_PAYLOAD)
            len = len % (MAX_SENT_PAYLOAD + 1);

        stream_q.push_back(hrmd_pkg::MAGIC_CHAR);
        stream_q.push_back(hrmd_pkg::MAGIC_CHAR);
        stream_q.push_back(mtype[15:8]);
        stream_q.push_back(mtype[7:0]);
        stream_q.push_back(len[31:24]);
        stream_q.push_back(len[23:16]);
        stream_q.push_back(len[15:8]);
        stream_q.push_back(len[7:0]);
        if (len <= cap)
            repeat (len) stream_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Cut the stream into reports. Counts are mostly in range, sometimes zero
    // or above the report payload (saturated). Some reports are cut short so
    // the next count byte arrives mid-report, and some full reports get junk
    // bytes past their count.
    task automatic send_stream();
        int unsigned sel;
        int unsigned count;
        int unsigned kept;
        int unsigned to_send;
        int unsigned n;
        while (stream_q.size() > 0) begin
            sel = $urandom_range(19);
            if (sel == 0)
                count = $urandom_range(hrmd_pkg::REPORT_PAYLOAD_DEF + 1, 255);
            else if (sel == 1)
                count = 0;
            else
                count = $urandom_range(1, hrmd_pkg::REPORT_PAYLOAD_DEF);
            kept = (count > hrmd_pkg::REPORT_PAYLOAD_DEF) ? hrmd_pkg::REPORT_PAYLOAD_DEF
                                                          : count;
            send_beat(8'(count), 1'b1);

            to_send = (kept > 1 && $urandom_range(14) == 0) ? $urandom_range(1, kept - 1)
                                                             : kept;
            n = 0;
            while (n < to_send && stream_q.size() > 0) begin
                send_beat(stream_q.pop_front(), 1'b0);
                phase_items++;
                n++;
            end
            if (n == kept && $urandom_range(7) == 0)
                repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = '0;
        in_if.report_start = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one oversized report (count saturates) carrying a
        // zero-length header with an all-ones type, a bad second magic, an
        // all-ones length over the reset limit, and a one-byte payload.
        stream_q = '{hrmd_pkg::MAGIC_CHAR, hrmd_pkg::MAGIC_CHAR, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'h00, 8'h00,
                     hrmd_pkg::MAGIC_CHAR, 8'h00,
                     hrmd_pkg::MAGIC_CHAR, hrmd_pkg::MAGIC_CHAR, 8'h00, 8'h00,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     hrmd_pkg::MAGIC_CHAR, hrmd_pkg::MAGIC_CHAR, 8'h12, 8'h34,
                     8'h00, 8'h00, 8'h00, 8'h01,
                     8'hFF};
        send_beat(8'hFF, 1'b1);
        while (stream_q.size() > 0)
            send_beat(stream_q.pop_front(), 1'b0);

        // Random phases, each under its own max_length. Phase 0 keeps the
        // reset value; the others write it, extremes included.
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: write_max_length('0);
                2: write_max_length('1);
                3: write_max_length(32'd7);
                4: write_max_length(32'($urandom_range(1, 40)));
                5: write_max_length($urandom);
                6: write_max_length(hrmd_pkg::MAX_LENGTH_RST);
                default: ;
            endcase
            // Phase 2 runs with no idling at all; phase 3 starts with the
            // receiver held off so the skid fills and input backs up.
            in_idle_pct  = (ph == 2) ? 0 : IDLE_PCT;
            out_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            if (ph == 3)
                hold_cycles = HOLD_OFF_CYCLES;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                add_message();
                send_stream();
            end
        end

        wait_drained();
        if (sb.n_errors == 0)
            $display("tb_hid_report_message_deframer: clean");
        else
            $display("tb_hid_report_message_deframer: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_hid_report_message_deframer: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hrmd_pkg.sv
rtl/hrmd_if.sv
rtl/hid_report_message_deframer.sv
dv/tb_hid_report_message_deframer.sv
